[rtl/complex_soft_threshold_defines.svh]
// Assertion macros shared by the complex soft threshold RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef COMPLEX_SOFT_THRESHOLD_DEFINES_SVH
`define COMPLEX_SOFT_THRESHOLD_DEFINES_SVH

// Implication check, disabled during reset
`define CST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check, disabled during reset
`define CST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cst_pkg.sv]
// Shared constants for the complex soft threshold block.
// No dependencies; used by the top level and the bench through scoped names.
`default_nettype none
package cst_pkg;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int THRESH_WIDTH     = 16;
  localparam int CFG_ADDR_W       = 2;
  localparam int CFG_DATA_W       = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 2'd0;
endpackage
`default_nettype wire

[rtl/cst_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with sideband.
// Uses no package items; instantiated by complex_soft_threshold.
`default_nettype none
module cst_isqrt #(
  parameter int W  = 16,
  parameter int SW = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2*W-1:0]   in_rad,
  input  wire logic [SW-1:0]    in_side,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [W-1:0]          out_root,
  output logic [SW-1:0]         out_side
);
  logic [W-1:0]     v_r;
  logic [W-1:0]     en;
  logic [2*W-1:0]   x_r    [W];
  logic [W+1:0]     rem_r  [W];
  logic [W-1:0]     root_r [W];
  logic [SW-1:0]    side_r [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic           v_in;
    logic [2*W-1:0] x_in;
    logic [W+1:0]   rem_in;
    logic [W-1:0]   root_in;
    logic [SW-1:0]  side_in;
    logic [W+1:0]   rem_t;
    logic [W+1:0]   trial;
    logic           ge;
    logic [W+1:0]   rem_nxt;
    logic [W-1:0]   root_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign x_in    = x_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    if (k == W-1) begin : g_last_en
      assign en[k] = ~v_r[k] | out_ready;
    end else begin : g_mid_en
      assign en[k] = ~v_r[k] | en[k+1];
    end

    // bring down the next pair of radicand bits and try root*4+1
    assign rem_t    = {rem_in[W-1:0], x_in[2*W-1 -: 2]};
    assign trial    = {root_in, 2'b01};
    assign ge       = rem_t >= trial;
    assign rem_nxt  = ge ? (rem_t - trial) : rem_t;
    assign root_nxt = {root_in[W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        x_r[k]    <= {x_in[2*W-3:0], 2'b00};
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[W-1];
  assign out_root  = root_r[W-1];
  assign out_side  = side_r[W-1];
endmodule
`default_nettype wire

[rtl/cst_div.sv]
// Pipelined restoring divider, two dividends over one shared divisor,
// one quotient bit per stage. No package items; used by the top level.
`default_nettype none
module cst_div #(
  parameter int W  = 16,
  parameter int SW = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2*W-1:0]   in_num_a,
  input  wire logic [2*W-1:0]   in_num_b,
  input  wire logic [W-1:0]     in_den,
  input  wire logic [SW-1:0]    in_side,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [W-1:0]          out_quo_a,
  output logic [W-1:0]          out_quo_b,
  output logic [SW-1:0]         out_side
);
  logic [W-1:0]     v_r;
  logic [W-1:0]     en;
  logic [2*W-1:0]   a_r    [W];
  logic [2*W-1:0]   b_r    [W];
  logic [W-1:0]     den_r  [W];
  logic [SW-1:0]    side_r [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic           v_in;
    logic [2*W-1:0] a_in;
    logic [2*W-1:0] b_in;
    logic [W-1:0]   den_in;
    logic [SW-1:0]  side_in;
    logic [W:0]     ta;
    logic [W:0]     tb;
    logic [W:0]     da;
    logic [W:0]     db;
    logic           gea;
    logic           geb;
    logic [2*W-1:0] a_nxt;
    logic [2*W-1:0] b_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign a_in    = in_num_a;
      assign b_in    = in_num_b;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign a_in    = a_r[k-1];
      assign b_in    = b_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    if (k == W-1) begin : g_last_en
      assign en[k] = ~v_r[k] | out_ready;
    end else begin : g_mid_en
      assign en[k] = ~v_r[k] | en[k+1];
    end

    // partial remainder sits in the upper half, quotient shifts in at the bottom
    assign ta    = a_in[2*W-1:W-1];
    assign tb    = b_in[2*W-1:W-1];
    assign gea   = ta >= {1'b0, den_in};
    assign geb   = tb >= {1'b0, den_in};
    assign da    = ta - {1'b0, den_in};
    assign db    = tb - {1'b0, den_in};
    assign a_nxt = gea ? {da[W-1:0], a_in[W-2:0], 1'b1} : {a_in[2*W-2:0], 1'b0};
    assign b_nxt = geb ? {db[W-1:0], b_in[W-2:0], 1'b1} : {b_in[2*W-2:0], 1'b0};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        a_r[k]    <= a_nxt;
        b_r[k]    <= b_nxt;
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[W-1];
  assign out_quo_a = a_r[W-1][W-1:0];
  assign out_quo_b = b_r[W-1][W-1:0];
  assign out_side  = side_r[W-1];
endmodule
`default_nettype wire

[rtl/complex_soft_threshold.sv]
// Complex soft thresholding of a stream of coefficients.
// Input: in_tdata carries real (low) and imaginary parts, in_tlast the block
// end flag. Output: the shrunk parts in out_tdata, out_tlast copied through.
// Per item: m = floor(sqrt(re^2+im^2)); if m <= threshold both parts are zero,
// else each part becomes trunc(part*(m-threshold)/m).
// Throughput: one transaction per cycle on both sides while out_tready stays high.
// Path: stages 1 to 3, the square-root pipeline, stages 4 and 5, the divider
// pipeline and stage 6; square root and divider each make one bit per stage.
// Every stage holds a valid bit and advances when the stage after it is empty
// or moving, so bubbles close up and a stalled receiver back-pressures the
// input only once every stage is full.
// Reset (rst_n low, synchronous) empties the pipeline and clears the
// threshold to zero. The threshold is written through the APB port at
// address 0 and should only be changed while the pipeline is empty.
// Depends on cst_pkg, cst_isqrt, cst_div and the assertion macro header.
`default_nettype none
`include "complex_soft_threshold_defines.svh"
module complex_soft_threshold #(
  parameter int SAMPLE_WIDTH = cst_pkg::SAMPLE_WIDTH_DEF,
  localparam int TDW = ((2*SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [TDW-1:0]                in_tdata,  // real_in, imag_in, zero pad
  input  wire logic                          in_tlast,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [TDW-1:0]                     out_tdata, // real_out, imag_out, zero pad
  output logic                               out_tlast,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [cst_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [cst_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [cst_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  localparam int W   = SAMPLE_WIDTH;
  localparam int TW  = cst_pkg::THRESH_WIDTH;
  localparam int CW  = (W > TW) ? W : TW;
  localparam int SSW = 2*W + 3;

  // ---------------- configuration ----------------
  logic [TW-1:0] thr_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr == cst_pkg::REG_THRESHOLD)
                      ? {{(cst_pkg::CFG_DATA_W-TW){1'b0}}, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_wr && cfg_paddr == cst_pkg::REG_THRESHOLD) begin
      thr_r <= cfg_pwdata[TW-1:0];
    end
  end

  // ---------------- stage 1: sign and magnitude ----------------
  logic         v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic         en1, en2, en3, en4, en5, en6;
  logic         sq_ready, sq_valid, dv_ready, dv_valid;
  logic [W-1:0] re_in, im_in;
  logic [W-1:0] mre1_r, mim1_r, mre2_r, mim2_r, mre3_r, mim3_r;
  logic [W-1:0] mre4_r, mim4_r;
  logic [2:0]   fl1_r, fl2_r, fl3_r, fl4_r, fl5_r, fl6_r; // {last, neg_im, neg_re}

  assign re_in = in_tdata[W-1:0];
  assign im_in = in_tdata[2*W-1:W];

  assign en6 = ~v6_r | out_tready;
  assign en5 = ~v5_r | dv_ready;
  assign en4 = ~v4_r | en5;
  assign en3 = ~v3_r | sq_ready;
  assign en2 = ~v2_r | en3;
  assign en1 = ~v1_r | en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= sq_valid;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      mre1_r <= re_in[W-1] ? (~re_in + 1'b1) : re_in;
      mim1_r <= im_in[W-1] ? (~im_in + 1'b1) : im_in;
      fl1_r  <= {in_tlast, im_in[W-1], re_in[W-1]};
    end
  end

  // ---------------- stages 2, 3: squares, then sum ----------------
  logic [2*W-1:0] sqre2_r, sqim2_r, sum3_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      sqre2_r <= {{W{1'b0}}, mre1_r} * {{W{1'b0}}, mre1_r};
      sqim2_r <= {{W{1'b0}}, mim1_r} * {{W{1'b0}}, mim1_r};
      mre2_r  <= mre1_r;
      mim2_r  <= mim1_r;
      fl2_r   <= fl1_r;
    end
    if (en3) begin
      sum3_r <= sqre2_r + sqim2_r;
      mre3_r <= mre2_r;
      mim3_r <= mim2_r;
      fl3_r  <= fl2_r;
    end
  end

  // ---------------- square root ----------------
  logic [W-1:0]   mag_root;
  logic [SSW-1:0] sq_side;

  cst_isqrt #(.W(W), .SW(SSW)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (sq_ready),
    .in_rad    (sum3_r),
    .in_side   ({fl3_r, mim3_r, mre3_r}),
    .out_valid (sq_valid),
    .out_ready (en4),
    .out_root  (mag_root),
    .out_side  (sq_side)
  );

  // ---------------- stage 4: shrink the magnitude ----------------
  logic [CW-1:0] m_ext, thr_ext, keep_full;
  logic          pass;
  logic [W-1:0]  keep4_r, den4_r, den5_r;

  assign m_ext     = CW'(mag_root);
  assign thr_ext   = CW'(thr_r);
  assign pass      = m_ext > thr_ext;   // also rules out a zero magnitude
  assign keep_full = m_ext - thr_ext;

  always_ff @(posedge clk) begin
    if (en4) begin
      // drop to zero keep over a unit divisor when nothing survives
      keep4_r <= pass ? keep_full[W-1:0] : '0;
      den4_r  <= pass ? mag_root : W'(1);
      mre4_r  <= sq_side[W-1:0];
      mim4_r  <= sq_side[2*W-1:W];
      fl4_r   <= sq_side[SSW-1:2*W];
    end
  end

  // ---------------- stage 5: products ----------------
  logic [2*W-1:0] pre5_r, pim5_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      pre5_r <= {{W{1'b0}}, mre4_r} * {{W{1'b0}}, keep4_r};
      pim5_r <= {{W{1'b0}}, mim4_r} * {{W{1'b0}}, keep4_r};
      den5_r <= den4_r;
      fl5_r  <= fl4_r;
    end
  end

  // ---------------- division ----------------
  logic [W-1:0] qre, qim;
  logic [2:0]   dv_side;

  cst_div #(.W(W), .SW(3)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v5_r),
    .in_ready  (dv_ready),
    .in_num_a  (pre5_r),
    .in_num_b  (pim5_r),
    .in_den    (den5_r),
    .in_side   (fl5_r),
    .out_valid (dv_valid),
    .out_ready (en6),
    .out_quo_a (qre),
    .out_quo_b (qim),
    .out_side  (dv_side)
  );

  // ---------------- stage 6: restore sign, output register ----------------
  logic [W-1:0] ore6_r, oim6_r;

  always_ff @(posedge clk) begin
    if (en6) begin
      ore6_r <= dv_side[0] ? (~qre + 1'b1) : qre;
      oim6_r <= dv_side[1] ? (~qim + 1'b1) : qim;
      fl6_r  <= dv_side;
    end
  end

  assign out_tvalid = v6_r;
  assign out_tdata  = TDW'({oim6_r, ore6_r});
  assign out_tlast  = fl6_r[2];

  // ---------------- checks ----------------
  `CST_ASSERT_IMP(a_ready_when_drained, !out_tvalid, in_tready,
    "input stalled although the output register is empty")
  `CST_ASSERT_IMP(a_den_nonzero, v4_r, den4_r != '0,
    "zero divisor entering the product stage")
  `CST_ASSERT_IMP(a_keep_below_mag, v4_r, keep4_r <= den4_r,
    "shrunk magnitude above the magnitude")
  `CST_ASSERT_NXT(a_stall_holds_output, out_tvalid && !out_tready && v6_r,
    v6_r, "output register lost a transaction during a stall")
endmodule
`default_nettype wire

[sim/tb_complex_soft_threshold.sv]
// Self-checking bench for complex_soft_threshold: stream driver, result monitor, APB writes.
// Predicts each output with an integer square root and truncating divide.
// Depends on cst_pkg and the complex_soft_threshold RTL.
`timescale 1ns / 1ps
module tb_complex_soft_threshold;
  localparam int SW = 16;
  localparam int LATENCY = 2*SW + 6;

  typedef struct packed {
    logic        last;
    logic [SW-1:0] im;
    logic [SW-1:0] re;
  } coef_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tlast;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [cst_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [cst_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [cst_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  complex_soft_threshold dut (.*);

  coef_t pending_coefs[$];
  coef_t shrunk_coefs[$];
  logic [15:0] thresh = '0;
  int mismatches = 0;
  bit quiet_phase = 1'b0;
  int in_gap = 0, out_gap = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] isqrt(logic [33:0] x);
    logic [33:0] r;
    begin
      r = 0;
      for (int b = 16; b >= 0; b--) begin
        if ((r + (34'd1 << b)) * (r + (34'd1 << b)) <= x) r = r + (34'd1 << b);
      end
      return r[31:0];
    end
  endfunction

  function automatic logic [SW-1:0] shrink_part(logic [SW-1:0] p, logic [31:0] keep,
                                                 logic [31:0] m);
    logic [16:0] a;
    logic [48:0] q;
    begin
      a = p[SW-1] ? 17'(-$signed({p[SW-1], p})) : {1'b0, p};
      q = ({32'd0, a} * {17'd0, keep}) / {17'd0, m};
      if (p[SW-1]) q = -q;
      return q[SW-1:0];
    end
  endfunction

  function automatic coef_t shrink(coef_t c);
    coef_t r;
    logic [16:0] ar, ai;
    logic [31:0] m;
    begin
      ar = c.re[SW-1] ? 17'(-$signed({c.re[SW-1], c.re})) : {1'b0, c.re};
      ai = c.im[SW-1] ? 17'(-$signed({c.im[SW-1], c.im})) : {1'b0, c.im};
      m = isqrt({17'd0, ar} * ar + {17'd0, ai} * ai);
      r = '0;
      r.last = c.last;
      if (m != 0 && m > thresh) begin
        r.re = shrink_part(c.re, m - thresh, m);
        r.im = shrink_part(c.im, m - thresh, m);
      end
      return r;
    end
  endfunction

  // driver: one transaction offered at a time, bursts of idle between
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        shrunk_coefs.push_back(shrink({in_tlast, in_tdata[31:16], in_tdata[15:0]}));
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_coefs.size() > 0) begin
          coef_t c;
          c = pending_coefs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {c.im, c.re};
          in_tlast <= c.last;
          if (!quiet_phase && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 4);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        coef_t got, want;
        got = {out_tlast, out_tdata[31:16], out_tdata[15:0]};
        if (shrunk_coefs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = shrunk_coefs.pop_front();
          if (got !== want || out_tdata[31:0] !== {want.im, want.re}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected re=%h im=%h last=%b, got re=%h im=%h last=%b",
                       want.re, want.im, want.last, got.re, got.im, got.last);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        out_gap <= $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_threshold(logic [15:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1;
    cfg_paddr <= cst_pkg::REG_THRESHOLD; cfg_pwdata <= {16'($urandom_range(0, 65535)), v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    thresh = v;
  endtask

  // sample at the falling edge so that every transaction of the rising edge has settled
  task automatic drain();
    while (pending_coefs.size() > 0 || in_tvalid || shrunk_coefs.size() > 0) @(negedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_part(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] edges[8];
    logic [15:0] settings[6];
    coef_t c;
    edges = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h8001, 16'h0100, 16'hff00};
    settings = '{16'd0, 16'd46341, 16'd1, 16'd100, 16'd30000, 16'd0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // directed: corners at zero threshold, then with a moderate one
    write_threshold(16'd0);
    for (int i = 0; i < 8; i++) begin
      c.re = edges[i]; c.im = edges[(i * 3) % 8]; c.last = i[0];
      pending_coefs.push_back(c);
    end
    c = '{1'b1, 16'h8000, 16'h8000};
    pending_coefs.push_back(c);
    drain();
    write_threshold(16'd256);
    for (int i = 0; i < 8; i++) begin
      c.re = edges[i]; c.im = edges[7 - i]; c.last = ~i[0];
      pending_coefs.push_back(c);
    end
    drain();
    // random phases across threshold settings
    for (int s = 0; s < 6; s++) begin
      write_threshold(s == 5 ? 16'($urandom_range(0, 46341)) : settings[s]);
      if (s == 5) quiet_phase = 1'b1;
      for (int i = 0; i < 180; i++) begin
        c.re = rand_part($urandom_range(0, 9));
        c.im = rand_part($urandom_range(0, 9));
        c.last = $urandom_range(0, 1);
        pending_coefs.push_back(c);
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/cst_pkg.sv
rtl/cst_isqrt.sv
rtl/cst_div.sv
rtl/complex_soft_threshold.sv
sim/tb_complex_soft_threshold.sv
